### rtl/core/dpbs_pkg.sv
// Package for the differential phase bit slicer: word types, register
// indexes, reset values and the CORDIC arctangent table.
// No dependencies.
package dpbs_pkg;

   // Sample width and default number of CORDIC cells
   localparam int SAMPLE_BITS           = 16;
   localparam int CORDIC_STAGES_DEFAULT = 16;
   localparam int ATAN_LEN              = 24;

   // Datapath width inside the cells: sample, pre-rotation and CORDIC gain
   localparam int CORDIC_BITS = SAMPLE_BITS + 3;
   localparam int ANGLE_BITS  = 16;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXPECTED_STEP      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DECISION_THRESHOLD = 2'd1;
   localparam int CSR_DATA_BITS = 16;

   // Reset values: 0.62 rad and a quarter of pi in binary angle units
   localparam logic signed [15:0] EXPECTED_STEP_RESET      = 16'sd6467;
   localparam logic        [14:0] DECISION_THRESHOLD_RESET = 15'd8192;

   // Quarter turn, for the pre-rotation
   localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = 16'h4000;

   // atan(2^-k) rounded to binary angle units
   localparam logic [ANGLE_BITS-1:0] ATAN_TABLE [0:ATAN_LEN-1] = '{
      16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
      16'd41,   16'd20,   16'd10,   16'd5,    16'd3,   16'd1,   16'd1,   16'd0,
      16'd0,    16'd0,    16'd0,    16'd0,    16'd0,   16'd0,   16'd0,   16'd0
   };

   typedef struct packed {
      logic signed [15:0] sample_i;
      logic signed [15:0] sample_q;
      logic               burst_start;
   } dpbs_req_type;

   typedef struct packed {
      logic               bit_value;
      logic signed [15:0] phase_step;
   } dpbs_rsp_type;

   // What one CORDIC cell hands to the next
   typedef struct packed {
      logic signed [CORDIC_BITS-1:0] x;
      logic signed [CORDIC_BITS-1:0] y;
      logic [ANGLE_BITS-1:0]         ang;
      logic                          start;
      logic                          zero;
   } dpbs_lane_type;

   // Configuration seen by the slicer
   typedef struct packed {
      logic signed [15:0] expected_step;
      logic [14:0]        decision_threshold;
   } dpbs_cfg_type;

endpackage

### rtl/core/dpbs_cell.sv
// One CORDIC vectoring cell of the phase chain: a single micro-rotation.
// Depends on dpbs_pkg.
module dpbs_cell #(
   parameter int IDX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  dpbs_pkg::dpbs_lane_type in_lane,
   output logic                   out_valid,
   output dpbs_pkg::dpbs_lane_type out_lane
);
   import dpbs_pkg::*;

   logic          valid_ff;
   dpbs_lane_type lane_ff;
   dpbs_lane_type lane_in;

   logic signed [CORDIC_BITS-1:0] xs;
   logic signed [CORDIC_BITS-1:0] ys;

   // Micro-rotation towards the positive x axis
   always_comb begin
      xs      = in_lane.x >>> IDX;
      ys      = in_lane.y >>> IDX;
      lane_in = in_lane;
      if (in_lane.y > 0) begin
         lane_in.x   = in_lane.x + ys;
         lane_in.y   = in_lane.y - xs;
         lane_in.ang = in_lane.ang + ATAN_TABLE[IDX];
      end else begin
         lane_in.x   = in_lane.x - ys;
         lane_in.y   = in_lane.y + xs;
         lane_in.ang = in_lane.ang - ATAN_TABLE[IDX];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lane_ff <= lane_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

endmodule

### rtl/core/dpbs_slicer.sv
// End of the chain: phase difference, threshold decision, and the output
// register with its skid stage. Depends on dpbs_pkg.
module dpbs_slicer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  dpbs_pkg::dpbs_lane_type in_lane,
   input  dpbs_pkg::dpbs_cfg_type  cfg,
   output logic                    hold,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output dpbs_pkg::dpbs_rsp_type  rsp_word
);
   import dpbs_pkg::*;

   logic [ANGLE_BITS-1:0] prev_phase_ff;
   logic                  have_prev_ff;
   logic                  rsp_valid_ff;
   dpbs_rsp_type          rsp_word_ff;
   logic                  skid_valid_ff;
   dpbs_rsp_type          skid_word_ff;

   logic [ANGLE_BITS-1:0] phase;
   logic [ANGLE_BITS-1:0] raw;
   logic signed [17:0]    dev;
   logic signed [17:0]    thr;
   logic                  take;
   logic                  push;
   logic                  pop;
   dpbs_rsp_type          new_word;

   // Chain moves only while the skid stage is free
   assign hold = skid_valid_ff;
   assign take = in_valid && !skid_valid_ff;
   assign pop  = rsp_valid_ff && !rsp_stall;

   // Wrapped step and deviation from the expected step
   always_comb begin
      phase = in_lane.zero ? '0 : in_lane.ang;
      raw   = phase - prev_phase_ff;
      dev   = 18'(cfg.expected_step) - 18'(signed'(raw));
      thr   = signed'({3'b000, cfg.decision_threshold});
      new_word.bit_value  = (dev > thr);
      new_word.phase_step = signed'(raw);
      push = take && !in_lane.start && have_prev_ff && ((dev > thr) || (dev < -thr));
   end

   // Previous phase follows every sample in order
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_phase_ff <= '0;
         have_prev_ff  <= 1'b0;
      end else if (take) begin
         prev_phase_ff <= phase;
         have_prev_ff  <= 1'b1;
      end
   end

   // Output register and skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (rsp_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            rsp_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            rsp_word_ff <= skid_word_ff;
         end
      end else if (push) begin
         if (rsp_valid_ff && !pop) begin
            skid_word_ff <= new_word;
         end else begin
            rsp_word_ff <= new_word;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

### rtl/core/differential_phase_bit_slicer.sv
//  channel | direction | handshake            | word
//  req     | in        | req_valid/req_stall  | sample_i, sample_q, burst_start
//  rsp     | out       | rsp_valid/rsp_stall  | bit_value, phase_step
//  csr     | in        | csr_we               | csr_index, csr_wdata
//
// One sample is taken every clock while req_stall is low. A sample that
// decides a bit passes the first CORDIC cell, which loads on the edge that
// takes it, then each further cell and the output register. Synchronous
// reset clears all valids and the held phase and sets the configuration
// registers to their reset values. A stalled result parks in the output
// register and a second in the skid stage; req_stall rises only while it is full.
//
// Top level of the differential phase bit slicer. Depends on dpbs_pkg,
// dpbs_cell and dpbs_slicer.
module differential_phase_bit_slicer #(
   parameter int CORDIC_STAGES = dpbs_pkg::CORDIC_STAGES_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  dpbs_pkg::dpbs_req_type                  req_word,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output dpbs_pkg::dpbs_rsp_type                  rsp_word,
   input  logic                                    csr_we,
   input  logic [dpbs_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [dpbs_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import dpbs_pkg::*;

   logic signed [15:0] expected_step_ff;
   logic [14:0]        decision_threshold_ff;
   dpbs_cfg_type       cfg;

   logic                  hold;
   logic                  advance;
   logic                  chain_valid [0:CORDIC_STAGES];
   dpbs_lane_type         chain_lane  [0:CORDIC_STAGES];
   logic signed [CORDIC_BITS-1:0] si;
   logic signed [CORDIC_BITS-1:0] sq;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_step_ff      <= EXPECTED_STEP_RESET;
         decision_threshold_ff <= DECISION_THRESHOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_EXPECTED_STEP: begin
               expected_step_ff <= signed'(csr_wdata[15:0]);
            end
            CSR_DECISION_THRESHOLD: begin
               decision_threshold_ff <= csr_wdata[14:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg.expected_step      = expected_step_ff;
   assign cfg.decision_threshold = decision_threshold_ff;

   assign advance   = !hold;
   assign req_stall = hold;

   // Pre-rotation by a quarter turn into the right half plane
   always_comb begin
      si = CORDIC_BITS'(signed'(req_word.sample_i[SAMPLE_BITS-1:0]));
      sq = CORDIC_BITS'(signed'(req_word.sample_q[SAMPLE_BITS-1:0]));
      chain_valid[0]      = req_valid;
      chain_lane[0].x     = si;
      chain_lane[0].y     = sq;
      chain_lane[0].ang   = '0;
      chain_lane[0].start = req_word.burst_start;
      chain_lane[0].zero  = (si == '0) && (sq == '0);
      if (si < 0) begin
         if (sq >= 0) begin
            chain_lane[0].x   = sq;
            chain_lane[0].y   = -si;
            chain_lane[0].ang = QUARTER_TURN;
         end else begin
            chain_lane[0].x   = -sq;
            chain_lane[0].y   = si;
            chain_lane[0].ang = -QUARTER_TURN;
         end
      end
   end

   // Row of CORDIC cells
   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
      dpbs_cell #(
         .IDX(k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (chain_valid[k]),
         .in_lane   (chain_lane[k]),
         .out_valid (chain_valid[k+1]),
         .out_lane  (chain_lane[k+1])
      );
   end

   dpbs_slicer u_slicer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[CORDIC_STAGES]),
      .in_lane   (chain_lane[CORDIC_STAGES]),
      .cfg       (cfg),
      .hold      (hold),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

### rtl/core/dpbs_checker.sv
// Port-level checks for the differential phase bit slicer, bound to the
// top level. Depends on dpbs_pkg and differential_phase_bit_slicer.
module dpbs_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input dpbs_pkg::dpbs_rsp_type rsp_word
);

   // A stalled result word stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed");

   // Nothing comes out the cycle after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   // Input only backs up while a result is waiting
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   // Input backs up only after the result side stalled
   assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_stall))
      else $error("input stall rose without an output stall");

   // A stalled input keeps req_valid high the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid)
      else $error("stalled input word withdrawn");

endmodule

bind differential_phase_bit_slicer dpbs_checker u_dpbs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

### bench/testbench.sv
// Self-checking bench for differential_phase_bit_slicer: a table of opening
// cases, then DPSK-like phasor bursts mixed with noise, checked word by word
// against a CORDIC slicer predictor kept here. Depends on dpbs_pkg and the RTL.
module testbench;
   import dpbs_pkg::*;

   localparam int STAGES         = CORDIC_STAGES_DEFAULT;
   localparam int SETTLE_CYCLES  = 2 * (STAGES + 1) + 8;
   localparam int STUCK_LIMIT    = 5000;
   localparam int LONG_HOLD      = 300;
   localparam int PHASE_ITEMS    = 95;
   localparam int PRESSURE_ITEMS = 60;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_B = 2'd3;
   localparam real PI_RAD = 3.14159265358979;

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_type;
   typedef enum logic [1:0] {WANT_MODEL, WANT_NONE, WANT_ONE, WANT_ZERO} want_type;

   typedef struct packed {
      row_kind_type              kind;
      want_type                  want;
      logic signed [15:0]        i;
      logic signed [15:0]        q;
      logic                      start;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_DATA_BITS-1:0]  wdata;
      logic signed [15:0]        typed_step;
   } plan_row_type;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   dpbs_req_type              req_word  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   dpbs_rsp_type              rsp_word;
   logic                      csr_we    = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // Predictor copy of registers and held phase
   logic signed [15:0] cfg_step      = EXPECTED_STEP_RESET;
   logic [14:0]        cfg_threshold = DECISION_THRESHOLD_RESET;
   logic [15:0]        held_phase    = '0;
   logic               held_valid    = 1'b0;
   dpbs_rsp_type       bits_due[$];

   logic [15:0] carrier     = '0;
   logic        gapless     = 1'b0;
   logic        hold_wanted = 1'b0;
   logic        hold_active = 1'b0;
   int mismatches    = 0;
   int samples_sent  = 0;
   int bits_checked  = 0;
   int regs_written  = 0;
   int stall_cycles  = 0;
   int idle_cycles   = 0;

   plan_row_type opening_plan[$];

   always #10 clock = ~clock;

   differential_phase_bit_slicer #(.CORDIC_STAGES(STAGES)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // atan(2^-k) in binary angle units
   function automatic int arctan_step(int k);
      case (k)
         0: return 8192;   1: return 4836;   2: return 2555;   3: return 1297;
         4: return 651;    5: return 326;    6: return 163;    7: return 81;
         8: return 41;     9: return 20;     10: return 10;    11: return 5;
         12: return 3;     13: return 1;     14: return 1;
         default: return 0;
      endcase
   endfunction

   // Vectoring CORDIC, quarter-turn pre-rotation for the left half-plane
   function automatic logic [15:0] cordic_angle(logic signed [15:0] si, logic signed [15:0] sq);
      longint x, y, t, xs, ys;
      int ang, k;
      x = si;
      y = sq;
      ang = 0;
      if (x == 0 && y == 0) return 16'h0000;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            ang = 16384;
         end else begin
            x = -y;
            y = t;
            ang = -16384;
         end
      end
      for (k = 0; k < STAGES && k < ATAN_LEN; k++) begin
         xs = x >>> k;
         ys = y >>> k;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            ang = ang + arctan_step(k);
         end else begin
            x = x - ys;
            y = y + xs;
            ang = ang - arctan_step(k);
         end
      end
      return ang[15:0];
   endfunction

   // Phase difference against the held phase, then the threshold decision
   function automatic bit slice_sample(dpbs_req_type w, output dpbs_rsp_type decided);
      logic [15:0] phase, raw;
      logic        fresh;
      int          dev, thr;
      phase = cordic_angle(w.sample_i, w.sample_q);
      fresh = w.burst_start || !held_valid;
      raw = phase - held_phase;
      held_phase = phase;
      held_valid = 1'b1;
      decided.phase_step = raw;
      dev = int'(cfg_step) - int'($signed(raw));
      thr = int'(cfg_threshold);
      if (fresh) return 1'b0;
      if (dev > thr) begin
         decided.bit_value = 1'b1;
         return 1'b1;
      end
      if (dev < -thr) begin
         decided.bit_value = 1'b0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Append to the expected-bit queue and to the opening table
   task automatic queue_bit(dpbs_rsp_type b);
      bits_due = {bits_due, b};
   endtask

   task automatic add_row(plan_row_type row);
      opening_plan = {opening_plan, row};
   endtask

   task automatic log_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   // Result checker and watchdog, sampled mid-cycle
   always @(negedge clock) begin : result_check
      dpbs_rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (bits_due.size() == 0) begin
               log_mismatch($sformatf("word with no bit due: bit %0d step %0d",
                                      rsp_word.bit_value, rsp_word.phase_step));
            end else begin
               want = bits_due.pop_front();
               if (rsp_word.bit_value !== want.bit_value)
                  log_mismatch($sformatf("bit_value %0d, predicted %0d",
                                         rsp_word.bit_value, want.bit_value));
               if (rsp_word.phase_step !== want.phase_step)
                  log_mismatch($sformatf("phase_step %0d, predicted %0d",
                                         rsp_word.phase_step, want.phase_step));
               bits_checked++;
            end
         end
         if (req_valid && req_stall) stall_cycles++;
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STUCK_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Output side: random stall runs, plus one long hold on request
   initial begin : receiver
      int run_left, r;
      logic level;
      run_left = 0;
      level = 1'b0;
      forever begin
         @(posedge clock);
         if (run_left <= 0) begin
            hold_active = 1'b0;
            if (hold_wanted) begin
               hold_wanted = 1'b0;
               hold_active = 1'b1;
               level = 1'b1;
               run_left = LONG_HOLD;
            end else begin
               r = $urandom_range(99);
               if (r < 50) begin
                  level = 1'b0;
                  run_left = $urandom_range(1, 4);
               end else if (r < 60) begin
                  level = 1'b0;
                  run_left = $urandom_range(20, 80);
               end else if (r < 90) begin
                  level = 1'b1;
                  run_left = $urandom_range(1, 3);
               end else if (r < 97) begin
                  level = 1'b1;
                  run_left = $urandom_range(4, 12);
               end else begin
                  level = 1'b1;
                  run_left = $urandom_range(20, 50);
               end
            end
         end
         rsp_stall <= level;
         run_left--;
      end
   end

   // Offer one word, wait for it to be taken, queue what it should produce
   task automatic send_sample(dpbs_req_type w, want_type want, logic signed [15:0] typed_step);
      logic stalled;
      dpbs_rsp_type decided;
      dpbs_rsp_type typed;
      bit produces;
      int gap, r;
      req_word <= w;
      req_valid <= 1'b1;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      samples_sent++;
      produces = slice_sample(w, decided);
      typed.phase_step = typed_step;
      typed.bit_value = (want == WANT_ONE);
      case (want)
         WANT_MODEL: if (produces) queue_bit(decided);
         WANT_ONE:   queue_bit(typed);
         WANT_ZERO:  queue_bit(typed);
         default: ;
      endcase
      r = $urandom_range(99);
      if (gapless || r < 55) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 15);
      else gap = $urandom_range(20, 60);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering, let every bit come out, then let the pipe empty
   task automatic drain;
      req_valid <= 1'b0;
      while (bits_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_EXPECTED_STEP:      cfg_step = data;
         CSR_DECISION_THRESHOLD: cfg_threshold = data[14:0];
         default: ;
      endcase
      regs_written++;
   endtask

   // Rotating phasor: for half the steps the deviation lands near either threshold
   function automatic dpbs_req_type phasor_sample(bit first);
      dpbs_req_type s;
      int dev, r, amp;
      real rad;
      r = $urandom_range(99);
      if (r < 25) dev = int'(cfg_threshold) + int'($urandom_range(64)) - 32;
      else if (r < 50) dev = -int'(cfg_threshold) + int'($urandom_range(64)) - 32;
      else dev = int'($urandom_range(65535)) - 32768;
      if (first) carrier = 16'($urandom);
      else carrier = carrier + 16'(int'(cfg_step) - dev);
      amp = ($urandom_range(9) == 0) ? $urandom_range(1, 63) : $urandom_range(64, 32767);
      rad = $itor($signed(carrier)) * PI_RAD / 32768.0;
      s.sample_i = 16'($rtoi(amp * $cos(rad)));
      s.sample_q = 16'($rtoi(amp * $sin(rad)));
      s.burst_start = first;
      return s;
   endfunction

   function automatic logic [15:0] rough_value();
      if ($urandom_range(4) != 0) return 16'($urandom);
      case ($urandom_range(4))
         0: return 16'h8000;
         1: return 16'hffff;
         2: return 16'h0000;
         3: return 16'h0001;
         default: return 16'h7fff;
      endcase
   endfunction

   function automatic dpbs_req_type noise_sample();
      dpbs_req_type s;
      s.sample_i = rough_value();
      s.sample_q = rough_value();
      s.burst_start = ($urandom_range(7) == 0);
      return s;
   endfunction

   // Mostly clean bursts; some noise and some bursts missing their start
   task automatic run_stream(int count);
      int left, len, kind, n;
      dpbs_req_type zero_word;
      zero_word = '0;
      left = count;
      while (left > 0) begin
         kind = $urandom_range(99);
         gapless = ($urandom_range(9) == 0);
         if (kind < 75) begin
            len = $urandom_range(3, 20);
            for (n = 0; n < len; n++)
               send_sample(phasor_sample(n == 0), WANT_MODEL, 16'sd0);
         end else if (kind < 90) begin
            len = $urandom_range(1, 6);
            for (n = 0; n < len; n++) send_sample(noise_sample(), WANT_MODEL, 16'sd0);
         end else begin
            len = $urandom_range(2, 8);
            for (n = 0; n < len; n++) begin
               if (n == len / 2) send_sample(zero_word, WANT_MODEL, 16'sd0);
               else send_sample(phasor_sample(1'b0), WANT_MODEL, 16'sd0);
            end
         end
         left -= len;
      end
      gapless = 1'b0;
   endtask

   function automatic plan_row_type sample_row(logic signed [15:0] i, logic signed [15:0] q,
                                               logic start, want_type want);
      plan_row_type row;
      row = '0;
      row.kind = ROW_SAMPLE;
      row.want = want;
      row.i = i;
      row.q = q;
      row.start = start;
      return row;
   endfunction

   function automatic plan_row_type write_row(logic [CSR_INDEX_BITS-1:0] idx,
                                              logic [CSR_DATA_BITS-1:0] data);
      plan_row_type row;
      row = '0;
      row.kind = ROW_WRITE;
      row.index = idx;
      row.wdata = data;
      return row;
   endfunction

   initial begin : stimulus
      int n, p, directed;
      logic [15:0] step_val, thr_val;
      dpbs_req_type w;

      // Reset settings: no previous phase, a zero step inside the band, burst start
      add_row(sample_row(16'sd0, 16'sd0, 1'b0, WANT_NONE));
      add_row(sample_row(16'sd0, 16'sd0, 1'b0, WANT_NONE));
      add_row(sample_row(16'sd32767, 16'sd0, 1'b1, WANT_NONE));
      add_row(sample_row(-16'sd32768, 16'sd0, 1'b0, WANT_MODEL));
      add_row(sample_row(-16'sd32768, -16'sd32768, 1'b0, WANT_MODEL));
      add_row(sample_row(16'sd32767, 16'sd32767, 1'b0, WANT_MODEL));
      add_row(sample_row(16'sd32767, -16'sd32768, 1'b0, WANT_MODEL));
      add_row(sample_row(-16'sd32768, 16'sd32767, 1'b0, WANT_MODEL));
      add_row(sample_row(16'sd0, -16'sd32768, 1'b0, WANT_MODEL));
      add_row(sample_row(16'sd1, 16'sd0, 1'b0, WANT_MODEL));
      add_row(sample_row(-16'sd1, -16'sd1, 1'b0, WANT_MODEL));
      add_row(sample_row(16'sd0, 16'sd0, 1'b1, WANT_NONE));
      // Largest step, zero threshold: zero samples decide a one
      add_row(write_row(CSR_EXPECTED_STEP, 16'h7fff));
      add_row(write_row(CSR_DECISION_THRESHOLD, 16'h0000));
      add_row(sample_row(16'sd0, 16'sd0, 1'b0, WANT_ONE));
      add_row(sample_row(16'sd0, 16'sd0, 1'b0, WANT_ONE));
      add_row(sample_row(16'sd0, 16'sd32767, 1'b0, WANT_MODEL));
      add_row(sample_row(-16'sd32768, -16'sd1, 1'b0, WANT_MODEL));
      // Most negative step, widest threshold; spare indexes must be ignored
      add_row(write_row(CSR_EXPECTED_STEP, 16'h8000));
      add_row(write_row(CSR_DECISION_THRESHOLD, 16'h7fff));
      add_row(write_row(CSR_SPARE_A, 16'hffff));
      add_row(write_row(CSR_SPARE_B, 16'h1234));
      add_row(sample_row(16'sd0, 16'sd0, 1'b1, WANT_NONE));
      add_row(sample_row(16'sd0, 16'sd0, 1'b0, WANT_ZERO));
      add_row(sample_row(16'sd32767, -16'sd1, 1'b0, WANT_MODEL));
      add_row(sample_row(-16'sd32768, 16'sd1, 1'b0, WANT_MODEL));
      // Top wdata bit dropped from the threshold; zero deviation stays silent
      add_row(write_row(CSR_DECISION_THRESHOLD, 16'hffff));
      add_row(write_row(CSR_EXPECTED_STEP, 16'h0000));
      add_row(sample_row(16'sd0, 16'sd0, 1'b1, WANT_NONE));
      add_row(sample_row(16'sd0, 16'sd0, 1'b0, WANT_NONE));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Opening cases
      for (n = 0; n < opening_plan.size(); n++) begin
         if (opening_plan[n].kind == ROW_WRITE) begin
            if (n > 0 && opening_plan[n-1].kind == ROW_SAMPLE) drain;
            write_reg(opening_plan[n].index, opening_plan[n].wdata);
         end else begin
            w.sample_i = opening_plan[n].i;
            w.sample_q = opening_plan[n].q;
            w.burst_start = opening_plan[n].start;
            send_sample(w, opening_plan[n].want, opening_plan[n].typed_step);
         end
      end
      directed = samples_sent;

      // Random streams under several register settings
      for (p = 0; p < 5; p++) begin
         case (p)
            0: begin
               step_val = EXPECTED_STEP_RESET;
               thr_val = {1'b0, DECISION_THRESHOLD_RESET};
            end
            2: begin
               step_val = 16'h8000;
               thr_val = 16'h0000;
            end
            3: begin
               step_val = 16'h7fff;
               thr_val = 16'hffff;
            end
            default: begin
               step_val = 16'($urandom);
               thr_val = {1'($urandom), 15'($urandom_range(16383))};
            end
         endcase
         drain;
         write_reg(CSR_EXPECTED_STEP, step_val);
         write_reg(CSR_DECISION_THRESHOLD, thr_val);
         if (p == 1) write_reg(CSR_SPARE_A, 16'($urandom));
         run_stream(PHASE_ITEMS);
      end

      // Long output hold with nearly every sample deciding a bit
      drain;
      write_reg(CSR_EXPECTED_STEP, 16'h7fff);
      write_reg(CSR_DECISION_THRESHOLD, 16'h0000);
      hold_wanted = 1'b1;
      while (!hold_active) @(posedge clock);
      gapless = 1'b1;
      for (n = 0; n < PRESSURE_ITEMS; n++) send_sample(noise_sample(), WANT_MODEL, 16'sd0);
      gapless = 1'b0;
      drain;

      $display("%0d samples (%0d from the opening table), %0d bits checked, %0d register writes",
               samples_sent, directed, bits_checked, regs_written);
      $display("input stalled for %0d cycles, output held off once for %0d cycles",
               stall_cycles, LONG_HOLD);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### differential_phase_bit_slicer.f
rtl/core/dpbs_pkg.sv
rtl/core/dpbs_cell.sv
rtl/core/dpbs_slicer.sv
rtl/core/differential_phase_bit_slicer.sv
rtl/core/dpbs_checker.sv
bench/testbench.sv
